/* rtl/vvl_pkg.sv */
// Shared constants and pipeline payload types for the voltage vector limiter.
// No dependencies.
`default_nettype none

package vvl_pkg;

	localparam int unsigned DIV1_STEPS = 28;
	localparam int unsigned DIV2_STEPS = 12;

	localparam logic [30:0] COEF_A0     = 31'd2130706431;
	localparam logic [30:0] COEF_B0     = 31'd402653183;
	localparam logic [30:0] COEF_A1     = 31'd1811939327;
	localparam logic [30:0] COEF_B1     = 31'd1191182335;
	localparam logic [12:0] SQRT3_Q12   = 13'd7094;
	localparam logic [11:0] SCALE_ONE   = 12'd4095;
	localparam logic [30:0] Q31_MAX     = 31'h7fff_ffff;
	localparam logic [14:0] LIMIT_RESET = 15'd4096;

	localparam logic REG_LIMIT = 1'b0;

	typedef struct packed {
		logic signed [31:0] d;
		logic signed [31:0] q;
		logic [30:0]        mag;
		logic               fault;
	} item_t;

	typedef struct packed {
		item_t       it;
		logic [14:0] den;
		logic [14:0] rem;
		logic [27:0] num;
	} div1_t;

	typedef struct packed {
		item_t       it;
		logic        lim;
		logic [27:0] den;
		logic [27:0] rem;
		logic [11:0] num;
	} div2_t;

endpackage

`default_nettype wire

/* rtl/voltage_vector_limiter_core.sv */
// Voltage vector limiter: alpha-max-beta-min magnitude, modulation index and scaling.
// One beat accepted each cycle; done is registered in step with the result outputs.
// Most of the latency sits in two bit-per-stage restoring dividers (28 and 12 stages).
// busy is held low: the pipeline never stalls, as results cannot be held off.
// Reset clears all valid bits and loads the limit register with 1.0 in Q3.12.
// Depends on vvl_pkg.
`default_nettype none

module voltage_vector_limiter_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] volt_d,
	input  wire logic signed [31:0] volt_q,
	input  wire logic [30:0]        bus_voltage,
	output logic                    done,
	output logic signed [31:0]      limited_d,
	output logic signed [31:0]      limited_q,
	output logic [30:0]             magnitude_estimate,
	output logic                    was_limited,
	output logic                    bus_fault,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import vvl_pkg::*;

	function automatic logic [30:0] abs_sat(input logic signed [31:0] x);
		logic [31:0] neg;
		neg = 32'(-x);
		if (x == 32'sh8000_0000)
			return Q31_MAX;
		return x[31] ? neg[30:0] : x[30:0];
	endfunction

	function automatic div1_t div1_step(input div1_t x);
		div1_t       y;
		logic [15:0] trial;
		logic        ge;
		y     = x;
		trial = {x.rem, x.num[27]};
		ge    = trial >= {1'b0, x.den};
		y.num = {x.num[26:0], ge};
		y.rem = ge ? 15'(trial - {1'b0, x.den}) : trial[14:0];
		return y;
	endfunction

	function automatic div2_t div2_step(input div2_t x);
		div2_t       y;
		logic [28:0] trial;
		logic        ge;
		y     = x;
		trial = {x.rem, x.num[11]};
		ge    = trial >= {1'b0, x.den};
		y.num = {x.num[10:0], ge};
		y.rem = ge ? 28'(trial - {1'b0, x.den}) : trial[27:0];
		return y;
	endfunction

	logic [14:0] limit_q;
	logic        cfg_wr;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [DIV1_STEPS-1:0] div1_v_s;
	logic [DIV2_STEPS-1:0] div2_v_s;

	item_t       it_s1, it_s2, it_s3, it_s4, it_s5, it_s8;
	logic [14:0] bhi_s1, bhi_s2, bhi_s3, bhi_s4, bhi_s5;
	logic [30:0] ad_s1, aq_s1, hi_s2, lo_s2;
	logic [61:0] p0_s3, p1_s3, p2_s3, p3_s3;
	logic [31:0] z0_s4, z1_s4;
	div1_t       div1_entry_s6;
	div1_t       div1_in [DIV1_STEPS];
	div1_t       div1_s  [DIV1_STEPS];
	div2_t       div2_entry_s7;
	div2_t       div2_in [DIV2_STEPS];
	div2_t       div2_s  [DIV2_STEPS];
	logic        lim_s8;
	logic [31:0] pd_s8, pq_s8;

	logic [62:0] sum0, sum1;
	logic [31:0] zmax;
	logic [27:0] idx;
	logic [26:0] numer;
	logic [11:0] fac;
	logic signed [19:0] dsh, qsh;
	logic signed [32:0] prod_d, prod_q;

	assign busy   = 1'b0;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LIMIT);
	assign prdata = (paddr[2] == REG_LIMIT) ? {17'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[14:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			div1_v_s <= '0;
			v_s7     <= 1'b0;
			div2_v_s <= '0;
			v_s8     <= 1'b0;
			done     <= 1'b0;
		end else begin
			v_s1     <= start;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			div1_v_s <= {div1_v_s[DIV1_STEPS-2:0], v_s6};
			v_s7     <= div1_v_s[DIV1_STEPS-1];
			div2_v_s <= {div2_v_s[DIV2_STEPS-2:0], v_s7};
			v_s8     <= div2_v_s[DIV2_STEPS-1];
			done     <= v_s8;
		end
	end

	assign sum0 = {1'b0, p0_s3} + {1'b0, p1_s3};
	assign sum1 = {1'b0, p2_s3} + {1'b0, p3_s3};
	assign zmax = (z0_s4 > z1_s4) ? z0_s4 : z1_s4;

	always_ff @(posedge clk) begin
		it_s1.d     <= volt_d;
		it_s1.q     <= volt_q;
		it_s1.mag   <= '0;
		it_s1.fault <= 1'b0;
		ad_s1       <= abs_sat(volt_d);
		aq_s1       <= abs_sat(volt_q);
		bhi_s1      <= bus_voltage[30:16];

		it_s2  <= it_s1;
		bhi_s2 <= bhi_s1;
		hi_s2  <= (ad_s1 > aq_s1) ? ad_s1 : aq_s1;
		lo_s2  <= (ad_s1 > aq_s1) ? aq_s1 : ad_s1;

		it_s3  <= it_s2;
		bhi_s3 <= bhi_s2;
		p0_s3  <= 62'(COEF_A0) * 62'(hi_s2);
		p1_s3  <= 62'(COEF_B0) * 62'(lo_s2);
		p2_s3  <= 62'(COEF_A1) * 62'(hi_s2);
		p3_s3  <= 62'(COEF_B1) * 62'(lo_s2);

		it_s4  <= it_s3;
		bhi_s4 <= bhi_s3;
		z0_s4  <= sum0[62:31];
		z1_s4  <= sum1[62:31];

		it_s5.d     <= it_s4.d;
		it_s5.q     <= it_s4.q;
		it_s5.mag   <= zmax[31] ? Q31_MAX : zmax[30:0];
		it_s5.fault <= (bhi_s4 == 15'd0);
		bhi_s5      <= bhi_s4;

		div1_entry_s6.it  <= it_s5;
		div1_entry_s6.den <= bhi_s5;
		div1_entry_s6.rem <= '0;
		div1_entry_s6.num <= 28'(it_s5.mag[30:16]) * 28'(SQRT3_Q12);
	end

	assign div1_in[0] = div1_entry_s6;

	for (genvar k = 0; k < DIV1_STEPS; k++) begin : g_div1
		if (k > 0) begin : g_link
			assign div1_in[k] = div1_s[k-1];
		end
		always_ff @(posedge clk) begin
			div1_s[k] <= div1_step(div1_in[k]);
		end
	end

	assign idx   = div1_s[DIV1_STEPS-1].num;
	assign numer = 27'(limit_q) * 27'(SCALE_ONE);

	always_ff @(posedge clk) begin
		div2_entry_s7.it  <= div1_s[DIV1_STEPS-1].it;
		div2_entry_s7.lim <= !div1_s[DIV1_STEPS-1].it.fault && (idx > 28'(limit_q));
		div2_entry_s7.den <= idx;
		div2_entry_s7.rem <= 28'(numer[26:12]);
		div2_entry_s7.num <= numer[11:0];
	end

	assign div2_in[0] = div2_entry_s7;

	for (genvar k = 0; k < DIV2_STEPS; k++) begin : g_div2
		if (k > 0) begin : g_link
			assign div2_in[k] = div2_s[k-1];
		end
		always_ff @(posedge clk) begin
			div2_s[k] <= div2_step(div2_in[k]);
		end
	end

	assign fac    = div2_s[DIV2_STEPS-1].num;
	assign dsh    = 20'(div2_s[DIV2_STEPS-1].it.d >>> 12);
	assign qsh    = 20'(div2_s[DIV2_STEPS-1].it.q >>> 12);
	assign prod_d = 33'(dsh) * $signed({21'd0, fac});
	assign prod_q = 33'(qsh) * $signed({21'd0, fac});

	always_ff @(posedge clk) begin
		it_s8  <= div2_s[DIV2_STEPS-1].it;
		lim_s8 <= div2_s[DIV2_STEPS-1].lim;
		pd_s8  <= prod_d[31:0];
		pq_s8  <= prod_q[31:0];

		limited_d          <= lim_s8 ? pd_s8 : it_s8.d;
		limited_q          <= lim_s8 ? pq_s8 : it_s8.q;
		magnitude_estimate <= it_s8.mag;
		was_limited        <= lim_s8;
		bus_fault          <= it_s8.fault;
	end

endmodule

`default_nettype wire
